>>> design/l1pb_pkg.sv
// Package for the L1 point bisection core: widths, states and shared types.
// No dependencies.
package l1pb_pkg;

    localparam int PosBits   = 32;
    localparam int RatioBits = 16;
    localparam int DivW      = 64;
    localparam int QuoBits   = 64 + PosBits;
    localparam int CntW      = 7;

    localparam logic [DivW-1:0] SatMax = {1'b0, {(DivW-1){1'b1}}};
    localparam logic [5:0] StepsReset = 6'd17;
    localparam logic [0:0] RegHalvingSteps = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_A,
        ST_DIV_B,
        ST_T1A,
        ST_T1B,
        ST_T2A,
        ST_T2B,
        ST_EVAL,
        ST_STEP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic            start;
        logic [DivW-1:0] num;
        logic [DivW-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic            done;
        logic [DivW-1:0] quo;
    } div_rsp_t;

endpackage

>>> design/l1pb_if.sv
// Valid/ready channel interfaces for the L1 point bisection core.
// No dependencies.
interface l1pb_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] mass_ratio;
    modport source (output valid, output mass_ratio, input ready);
    modport sink (input valid, input mass_ratio, output ready);
endinterface

interface l1pb_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] l1_position;
    logic        exact_hit;
    modport source (output valid, output l1_position, output exact_hit, input ready);
    modport sink (input valid, input l1_position, input exact_hit, output ready);
endinterface

>>> design/l1pb_divider.sv
// Restoring divider: floor(num * 2^PosBits / den), saturated to 2^63-1.
// One quotient bit per cycle. Depends on l1pb_pkg.
module l1pb_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  l1pb_pkg::div_req_t req,
    output l1pb_pkg::div_rsp_t rsp
);
    logic [l1pb_pkg::DivW-1:0]    num_reg, num_next;
    logic [l1pb_pkg::DivW-1:0]    den_reg, den_next;
    logic [l1pb_pkg::DivW:0]      rem_reg, rem_next;
    logic [l1pb_pkg::DivW-1:0]    quo_reg, quo_next;
    logic                         over_reg, over_next;
    logic [l1pb_pkg::CntW-1:0]    cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [l1pb_pkg::DivW:0]      shifted;
    logic                         bit_in;

    always_comb
    begin
        // bits beyond the numerator are the appended zeros
        bit_in = (cnt_reg >= l1pb_pkg::CntW'(l1pb_pkg::PosBits)) ?
                 num_reg[l1pb_pkg::DivW-1] : 1'b0;
        shifted = {rem_reg[l1pb_pkg::DivW-1:0], bit_in};
        num_next = num_reg; den_next = den_reg; rem_next = rem_reg;
        quo_next = quo_reg; over_next = over_reg; cnt_next = cnt_reg;
        busy_next = busy_reg; done_next = 1'b0;
        if (req.start)
        begin
            num_next = req.num; den_next = req.den; rem_next = '0;
            quo_next = '0; over_next = 1'b0;
            cnt_next = l1pb_pkg::CntW'(l1pb_pkg::QuoBits - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg >= l1pb_pkg::CntW'(l1pb_pkg::PosBits))
                num_next = {num_reg[l1pb_pkg::DivW-2:0], 1'b0};
            if (quo_reg[l1pb_pkg::DivW-1] || quo_reg[l1pb_pkg::DivW-2])
                over_next = 1'b1;
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = shifted - {1'b0, den_reg};
                quo_next = {quo_reg[l1pb_pkg::DivW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[l1pb_pkg::DivW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        over_reg <= over_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = (over_reg || quo_reg[l1pb_pkg::DivW-1]) ? l1pb_pkg::SatMax : quo_reg;
endmodule

>>> design/l1_point_bisection_core.sv
// Top level of the L1 point bisection core: sequencer, APB register, datapath.
// Depends on l1pb_pkg, l1pb_if and l1pb_divider.
//
//  channel  | dir | handshake      | payload
//  in_ch    | in  | valid/ready    | mass_ratio
//  out_ch   | out | valid/ready    | l1_position, exact_hit
//  apb      | in  | psel/penable   | halving_steps at address 0
//
// Each item takes two divisions for a and b plus four per function value, all done in turn on the one shared divider.
// rst_n clears the sequencer and sets halving_steps to 17.
// in_ch is not ready until the result has been taken from out_ch.
module l1_point_bisection_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    l1pb_in_if.sink     in_ch,
    l1pb_out_if.source  out_ch
);
    localparam int W = l1pb_pkg::DivW;
    localparam int P = l1pb_pkg::PosBits;

    l1pb_pkg::state_t state_reg, state_next;
    logic [5:0]   steps_reg;
    logic [W-1:0] q_reg, q_next, a_reg, a_next, b_reg, b_next;
    logic [W-1:0] left_reg, left_next, right_reg, right_next, x_reg, x_next;
    logic [W-1:0] t1_reg, t1_next;
    logic signed [W-1:0] fl_reg, fl_next;
    logic [5:0]   k_reg, k_next;
    logic         first_reg, first_next;
    logic [31:0]  pos_reg, pos_next;
    logic         hit_reg, hit_next;
    l1pb_pkg::div_req_t dreq;
    l1pb_pkg::div_rsp_t drsp;
    logic [W-1:0] y, mid, fin_mid;
    logic signed [W:0] diff, fval_wide;
    logic signed [W-1:0] fval;
    logic to_right;

    l1pb_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign pready = 1'b1;
    assign prdata = {26'd0, steps_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            steps_reg <= l1pb_pkg::StepsReset;
        else if (psel && penable && pwrite
                 && paddr == {l1pb_pkg::RegHalvingSteps, 1'b0} && 1'b1)
            steps_reg <= pwdata[5:0];
    end

    assign y = (W'(1) << P) - x_reg;
    assign mid = (left_reg + right_reg) >> 1;
    // t1 - t2 - (x - b), saturated
    assign diff = $signed({1'b0, t1_reg}) - $signed({1'b0, drsp.quo})
                - ($signed({1'b0, x_reg}) - $signed({1'b0, b_reg}));
    assign fval_wide = diff;
    always_comb
    begin
        if (fval_wide > $signed({2'b00, {(W-1){1'b1}}}))
            fval = $signed(l1pb_pkg::SatMax);
        else if (fval_wide < -$signed({2'b01, {(W-1){1'b0}}}))
            fval = $signed({1'b1, {(W-1){1'b0}}});
        else
            fval = fval_wide[W-1:0];
    end
    assign to_right = (fl_reg > 0) ? (fval < 0) : (fval > 0);
    assign fin_mid = mid;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            l1pb_pkg::ST_IDLE:  if (in_ch.valid) state_next = l1pb_pkg::ST_DIV_A;
            l1pb_pkg::ST_DIV_A: if (drsp.done) state_next = l1pb_pkg::ST_DIV_B;
            l1pb_pkg::ST_DIV_B: if (drsp.done) state_next = l1pb_pkg::ST_T1A;
            l1pb_pkg::ST_T1A:   if (drsp.done) state_next = l1pb_pkg::ST_T1B;
            l1pb_pkg::ST_T1B:   if (drsp.done) state_next = l1pb_pkg::ST_T2A;
            l1pb_pkg::ST_T2A:   if (drsp.done) state_next = l1pb_pkg::ST_T2B;
            l1pb_pkg::ST_T2B:   if (drsp.done) state_next = l1pb_pkg::ST_EVAL;
            l1pb_pkg::ST_EVAL:
                if (!first_reg && fval == 0) state_next = l1pb_pkg::ST_DONE;
                else state_next = l1pb_pkg::ST_STEP;
            l1pb_pkg::ST_STEP:
                if (k_reg >= steps_reg) state_next = l1pb_pkg::ST_DONE;
                else state_next = l1pb_pkg::ST_T1A;
            l1pb_pkg::ST_DONE:  if (out_ch.ready) state_next = l1pb_pkg::ST_IDLE;
            default: state_next = l1pb_pkg::ST_IDLE;
        endcase
    end

    // divider start pulses on entry to each division state, and the datapath register updates
    always_comb
    begin
        dreq = '0;
        q_next = q_reg; a_next = a_reg; b_next = b_reg;
        left_next = left_reg; right_next = right_reg; x_next = x_reg;
        t1_next = t1_reg; fl_next = fl_reg; k_next = k_reg;
        first_next = first_reg; pos_next = pos_reg; hit_next = hit_reg;
        unique case (state_reg)
            l1pb_pkg::ST_IDLE:
                if (in_ch.valid)
                begin
                    q_next = W'(in_ch.mass_ratio);
                    dreq.start = 1'b1;
                    dreq.num = W'(1) << l1pb_pkg::RatioBits;
                    dreq.den = (W'(1) << l1pb_pkg::RatioBits) + W'(in_ch.mass_ratio);
                end
            l1pb_pkg::ST_DIV_A:
                if (drsp.done)
                begin
                    a_next = drsp.quo;
                    dreq.start = 1'b1;
                    dreq.num = q_reg;
                    dreq.den = (W'(1) << l1pb_pkg::RatioBits) + q_reg;
                end
            l1pb_pkg::ST_DIV_B:
                if (drsp.done)
                begin
                    b_next = drsp.quo;
                    left_next = W'(1);
                    right_next = (W'(1) << P) - W'(1);
                    x_next = W'(1);
                    k_next = '0;
                    first_next = 1'b1;
                    dreq.start = 1'b1;
                    dreq.num = a_reg;
                    dreq.den = W'(1);
                end
            l1pb_pkg::ST_T1A:
                if (drsp.done)
                begin
                    dreq.start = 1'b1;
                    dreq.num = drsp.quo;
                    dreq.den = x_reg;
                end
            l1pb_pkg::ST_T1B:
                if (drsp.done)
                begin
                    t1_next = drsp.quo;
                    dreq.start = 1'b1;
                    dreq.num = b_reg;
                    dreq.den = y;
                end
            l1pb_pkg::ST_T2A:
                if (drsp.done)
                begin
                    dreq.start = 1'b1;
                    dreq.num = drsp.quo;
                    dreq.den = y;
                end
            l1pb_pkg::ST_T2B: ;
            l1pb_pkg::ST_EVAL:
            begin
                if (first_reg)
                    fl_next = fval;
                else if (fval == 0)
                begin
                    pos_next = x_reg[P-1:P-32];
                    hit_next = 1'b1;
                end
                else if (to_right)
                    right_next = x_reg;
                else
                begin
                    left_next = x_reg;
                    fl_next = fval;
                end
                if (!first_reg)
                    k_next = k_reg + 6'd1;
                first_next = 1'b0;
            end
            l1pb_pkg::ST_STEP:
                if (k_reg >= steps_reg)
                begin
                    pos_next = fin_mid[P-1:P-32];
                    hit_next = 1'b0;
                end
                else
                begin
                    x_next = mid;
                    dreq.start = 1'b1;
                    dreq.num = a_reg;
                    dreq.den = mid;
                end
            l1pb_pkg::ST_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= l1pb_pkg::ST_IDLE;
            k_reg     <= '0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next; a_reg <= a_next; b_reg <= b_next;
        left_reg <= left_next; right_reg <= right_next; x_reg <= x_next;
        t1_reg <= t1_next; fl_reg <= fl_next;
        pos_reg <= pos_next; hit_reg <= hit_next;
    end

    assign in_ch.ready = (state_reg == l1pb_pkg::ST_IDLE);
    assign out_ch.valid = (state_reg == l1pb_pkg::ST_DONE);
    assign out_ch.l1_position = pos_reg;
    assign out_ch.exact_hit = hit_reg;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && out_ch.valid)) else $error("ready while result pending");
    a_div_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        drsp.done |-> (state_reg != l1pb_pkg::ST_IDLE && state_reg != l1pb_pkg::ST_DONE))
        else $error("divider result outside a division state");
    a_left_below_right: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == l1pb_pkg::ST_STEP) |-> (left_reg < right_reg))
        else $error("bisection interval collapsed");
endmodule
